### hw/rtl/ffba_pkg.sv
// Package for the first-fit block allocator.
// Holds command and status codes, the transfer structs and default sizes.
// No dependencies.
`default_nettype none
package ffba_pkg;

  localparam int OFFSET_W = 12;
  localparam int MINREQ_W = 7;
  localparam int ARENA_BYTES_DEF = 4096;
  localparam int HEADER_BYTES_DEF = 17;
  localparam logic [MINREQ_W-1:0] MIN_REQUEST_RESET = 7'd8;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  typedef struct packed {
    logic cmd;
    logic [OFFSET_W-1:0] request_size;
    logic [OFFSET_W-1:0] release_offset;
  } in_item_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] payload_offset;
    logic [1:0] status;
  } out_item_t;

endpackage
`default_nettype wire

### hw/rtl/first_fit_block_allocator.sv
// First-fit block allocator: sequencer that walks the header chain in memory.
// Depends on ffba_pkg and ffba_hdr_ram.
//
// Channel  Dir  Handshake            Payload
// in       in   in_valid/in_stall    in_data (ffba_pkg::in_item_t)
// out      out  out_valid/out_stall  out_data (ffba_pkg::out_item_t)
// cfg      in   cfg_write            cfg_data (min_request)
//
// After reset a clearing pass writes every header entry.
// Allocate: accept, a merge pass on the first block, then per block a header read (none
// for the first), a check and a merge pass when skipped; reading a free block's
// successor adds a read, a merge adds a write. A grant adds split and header writes.
// Free: an offset below the header fails at once, a missing header after the read.
// One item at a time; a result waits in the output register under out_stall.
`default_nettype none
module first_fit_block_allocator #(
  parameter int ARENA_BYTES = ffba_pkg::ARENA_BYTES_DEF,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_stall,
  input wire ffba_pkg::in_item_t in_data,
  output logic out_valid,
  input wire logic out_stall,
  output ffba_pkg::out_item_t out_data,
  input wire logic cfg_write,
  input wire logic [ffba_pkg::MINREQ_W-1:0] cfg_data
);

  localparam int AW = $clog2(ARENA_BYTES);
  localparam int CW = AW + 1;
  localparam int EW = CW + AW + 3;
  localparam int XW = ((AW > ffba_pkg::OFFSET_W) ? AW : ffba_pkg::OFFSET_W) + 2;

  localparam logic [3:0] S_CLR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_HRD = 4'd2;
  localparam logic [3:0] S_JN = 4'd3;
  localparam logic [3:0] S_NRD = 4'd4;
  localparam logic [3:0] S_JW = 4'd5;
  localparam logic [3:0] S_JEND = 4'd6;
  localparam logic [3:0] S_CHK = 4'd7;
  localparam logic [3:0] S_SPL = 4'd8;
  localparam logic [3:0] S_GWR = 4'd9;
  localparam logic [3:0] S_RES = 4'd10;

  logic [3:0] state;
  logic [AW:0] clr;
  logic [ffba_pkg::MINREQ_W-1:0] min_request;
  logic mode;
  logic pre;
  logic [XW-1:0] q;
  logic [AW-1:0] cur_h;
  logic [CW-1:0] cur_cap;
  logic [AW-1:0] cur_next;
  logic [AW-1:0] cur_next_old;
  logic cur_hn;
  logic cur_free;
  logic cur_valid;
  logic [EW-1:0] nbuf;
  logic [AW-1:0] nh;
  logic do_split;
  ffba_pkg::out_item_t res;

  logic ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [AW-1:0] ram_raddr_sel;
  logic [EW-1:0] ram_rdata;

  logic [CW-1:0] rd_cap;
  logic [AW-1:0] rd_next;
  logic rd_hn;
  logic rd_free;
  logic rd_valid;
  logic [CW-1:0] merged_cap;
  logic [XW-1:0] req_x;
  logic [XW-1:0] q_in;
  logic [XW-1:0] hf;
  logic bad_free;
  logic fits;
  logic [XW-1:0] rem;
  logic [XW-1:0] nh_x;
  logic split_ok;
  logic out_free;

  assign rd_cap = ram_rdata[EW-1 -: CW];
  assign rd_next = ram_rdata[AW+2:3];
  assign rd_hn = ram_rdata[2];
  assign rd_free = ram_rdata[1];
  assign rd_valid = ram_rdata[0];
  assign merged_cap = cur_cap + rd_cap + CW'(HEADER_BYTES);

  assign req_x = XW'(in_data.request_size);
  assign q_in = (req_x < XW'(min_request)) ? XW'(min_request) : req_x;
  assign hf = XW'(in_data.release_offset) - XW'(HEADER_BYTES);
  assign bad_free = (XW'(in_data.release_offset) < XW'(HEADER_BYTES))
                    || (hf >= XW'(ARENA_BYTES));

  assign fits = cur_free && (XW'(cur_cap) >= q);
  assign rem = XW'(cur_cap) - q;
  assign nh_x = XW'(cur_h) + XW'(HEADER_BYTES) + q;
  assign split_ok = (rem >= XW'(min_request) + XW'(HEADER_BYTES))
                    && (nh_x < XW'(ARENA_BYTES));
  assign out_free = !out_valid || !out_stall;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = cur_h;
    ram_wdata = {cur_cap, cur_next, cur_hn, cur_free, cur_valid};
    ram_raddr = cur_next;
    case (state)
      S_CLR: begin
        ram_we = 1'b1;
        ram_waddr = clr[AW-1:0];
        ram_wdata = (clr == '0) ?
            {CW'(ARENA_BYTES - HEADER_BYTES), {AW{1'b0}}, 1'b0, 1'b1, 1'b1} : '0;
      end
      S_IDLE: begin
        ram_raddr = (in_data.cmd == ffba_pkg::CMD_FREE) ? hf[AW-1:0] : '0;
      end
      S_NRD: begin
        ram_we = rd_free;
        ram_wdata = {merged_cap, rd_next, rd_hn, cur_free, cur_valid};
      end
      S_JW: begin
        ram_we = 1'b1;
        ram_waddr = cur_next_old;
        ram_wdata = {nbuf[EW-1:3], 1'b0, nbuf[1], 1'b0};
        ram_wdata[2] = 1'b0;
      end
      S_JEND: begin
        ram_we = (mode == ffba_pkg::CMD_FREE);
      end
      S_SPL: begin
        ram_we = do_split;
        ram_waddr = nh;
        ram_wdata = nbuf;
      end
      S_GWR: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr <= '0;
      min_request <= ffba_pkg::MIN_REQUEST_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        min_request <= cfg_data;
      end
      if (out_valid && !out_stall && (state != S_RES)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr <= clr + 1'b1;
          if (clr == (AW+1)'(ARENA_BYTES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            mode <= in_data.cmd;
            pre <= 1'b1;
            q <= q_in;
            if (in_data.cmd == ffba_pkg::CMD_FREE) begin
              cur_h <= hf[AW-1:0];
              if (bad_free) begin
                res <= '{payload_offset: '0, status: ffba_pkg::ST_BAD};
                state <= S_RES;
              end else begin
                state <= S_HRD;
              end
            end else begin
              cur_h <= '0;
              state <= S_HRD;
            end
          end
        end
        S_HRD: begin
          cur_cap <= rd_cap;
          cur_next <= rd_next;
          cur_hn <= rd_hn;
          cur_valid <= rd_valid;
          if (mode == ffba_pkg::CMD_FREE) begin
            cur_free <= 1'b1;
            if (!rd_valid) begin
              res <= '{payload_offset: '0, status: ffba_pkg::ST_BAD};
              state <= S_RES;
            end else begin
              state <= S_JN;
            end
          end else begin
            cur_free <= rd_free;
            state <= pre ? S_JN : S_CHK;
          end
        end
        S_JN: begin
          state <= (cur_free && cur_hn) ? S_NRD : S_JEND;
        end
        S_NRD: begin
          if (rd_free) begin
            nbuf <= ram_rdata;
            cur_next_old <= cur_next;
            cur_cap <= merged_cap;
            cur_next <= rd_next;
            cur_hn <= rd_hn;
            state <= S_JW;
          end else begin
            state <= S_JEND;
          end
        end
        S_JW: begin
          state <= S_JEND;
        end
        S_JEND: begin
          if (mode == ffba_pkg::CMD_FREE) begin
            res <= '{payload_offset: '0, status: ffba_pkg::ST_OK};
            state <= S_RES;
          end else if (pre) begin
            pre <= 1'b0;
            state <= S_CHK;
          end else if (!cur_hn) begin
            res <= '{payload_offset: '0, status: ffba_pkg::ST_OOM};
            state <= S_RES;
          end else begin
            cur_h <= cur_next;
            state <= S_HRD;
          end
        end
        S_CHK: begin
          if (fits) begin
            do_split <= split_ok;
            nh <= nh_x[AW-1:0];
            nbuf <= {CW'(rem - XW'(HEADER_BYTES)), cur_next, cur_hn, 1'b1, 1'b1};
            cur_free <= 1'b0;
            if (split_ok) begin
              cur_cap <= CW'(q);
              cur_next <= nh_x[AW-1:0];
              cur_hn <= 1'b1;
            end
            state <= S_SPL;
          end else begin
            state <= S_JN;
          end
        end
        S_SPL: begin
          state <= S_GWR;
        end
        S_GWR: begin
          res <= '{payload_offset: ffba_pkg::OFFSET_W'(XW'(cur_h) + XW'(HEADER_BYTES)),
                   status: ffba_pkg::ST_OK};
          state <= S_RES;
        end
        S_RES: begin
          if (out_free) begin
            out_data <= res;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    ram_raddr_sel = ram_raddr;
    if (state == S_JEND) begin
      ram_raddr_sel = cur_next;
    end else if (state == S_GWR || state == S_SPL || state == S_CHK) begin
      ram_raddr_sel = cur_h;
    end
  end

  ffba_hdr_ram #(
    .DEPTH(ARENA_BYTES),
    .AW(AW),
    .EW(EW)
  ) u_hdr_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr_sel),
    .rdata(ram_rdata)
  );

  a_clr_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> in_stall)
    else $error("input taken during clearing pass");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !ram_we)
    else $error("header write while idle");

  a_grant_used: assert property (@(posedge clk) disable iff (rst)
    (state == S_GWR) |-> !cur_free)
    else $error("granted block still marked free");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transfer taken while busy");

endmodule
`default_nettype wire

### hw/rtl/ffba_hdr_ram.sv
// Block header memory: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none
module ffba_hdr_ram #(
  parameter int DEPTH = 4096,
  parameter int AW = 12,
  parameter int EW = 28
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [AW-1:0] waddr,
  input wire logic [EW-1:0] wdata,
  input wire logic [AW-1:0] raddr,
  output logic [EW-1:0] rdata
);

  logic [EW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
